>>> rtl/pit_pkg.sv
// Shared types, constants and helpers for the paired interval timer.
// Used by pit_cfg, pit_sched and paired_interval_timer; no dependencies.
package pit_pkg;

    // widths
    localparam int PERIOD_WIDTH_DEF = 32;
    localparam int DIV_W   = 13;
    localparam int CMP_W   = 8;
    localparam int CNT_W   = 9;
    localparam int TICKS_W = 17;
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;
    localparam int CFG_REGS = 4;

    // full-range tick counts for a zero compare value
    localparam logic [CNT_W-1:0]   FULL8  = CNT_W'(256);
    localparam logic [TICKS_W-1:0] FULL16 = TICKS_W'(65536);

    // prescale divisors after reset: t1, t4, t16, t256
    localparam logic [DIV_W-1:0] DIV_RST [CFG_REGS] = '{13'd8, 13'd32, 13'd128, 13'd2048};

    typedef struct packed {
        logic [DIV_W-1:0] t1;
        logic [DIV_W-1:0] t4;
        logic [DIV_W-1:0] t16;
        logic [DIV_W-1:0] t256;
    } t_divs;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_EXT   = 2'd3
    } t_func;

    // register addresses
    localparam logic [7:0] ADDR_RUN   = 8'h20;
    localparam logic [7:0] ADDR_CMP0  = 8'h22;
    localparam logic [7:0] ADDR_CMP1  = 8'h23;
    localparam logic [7:0] ADDR_MODE0 = 8'h24;
    localparam logic [7:0] ADDR_FFC   = 8'h25;
    localparam logic [7:0] ADDR_CMP2  = 8'h26;
    localparam logic [7:0] ADDR_CMP3  = 8'h27;
    localparam logic [7:0] ADDR_MODE1 = 8'h28;
    localparam logic [7:0] ADDR_DBC   = 8'h29;

    // flip-flop control reads back with these bits set
    localparam logic [7:0] FFC_READ_SET = 8'hCC;

    // pair mode field, mode byte bits 7:6
    localparam logic [1:0] PAIR_CASCADE = 2'd0;
    localparam logic [1:0] PAIR_16      = 2'd1;

    // source select field
    localparam logic [1:0] SRC_EXT  = 2'd0;
    localparam logic [1:0] SRC_T1   = 2'd1;
    localparam logic [1:0] SRC_MID  = 2'd2;
    localparam logic [1:0] SRC_HIGH = 2'd3;

    // flip-flop control codes
    localparam logic [1:0] FF_TOGGLE = 2'd0;
    localparam logic [1:0] FF_SET    = 2'd1;
    localparam logic [1:0] FF_CLEAR  = 2'd2;
    localparam logic [1:0] FF_HOLD   = 2'd3;

    // counts for an 8-bit compare, zero meaning full range
    function automatic logic [CNT_W-1:0] ticks8(input logic [CMP_W-1:0] cv);
        return (cv == '0) ? FULL8 : CNT_W'(cv);
    endfunction

endpackage

>>> rtl/pit_cfg.sv
// APB-style register port holding the four prescale divisors.
// Depends on pit_pkg.
module pit_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pit_pkg::CFG_AW-1:0]  paddr,
    input  logic [pit_pkg::CFG_DW-1:0]  pwdata,
    output logic [pit_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output pit_pkg::t_divs              o_div
);
    import pit_pkg::*;

    logic [DIV_W-1:0] r_div [CFG_REGS];
    logic [1:0]       w_idx;
    logic             w_wr;

    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = CFG_DW'(r_div[w_idx]);

    // divisor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_div[i] <= DIV_RST[i];
            end
        end else if (w_wr) begin
            r_div[w_idx] <= pwdata[DIV_W-1:0];
        end
    end

    assign o_div = '{t1: r_div[0], t4: r_div[1], t16: r_div[2], t256: r_div[3]};

endmodule

>>> rtl/pit_sched.sv
// Period unit for one timer: picks the divisor, forms the tick count and
// multiplies them into a saturated countdown length. Depends on pit_pkg.
module pit_sched #(
    parameter int PERIOD_WIDTH = pit_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                        i_odd,
    input  logic                        i_run,
    input  logic [pit_pkg::CMP_W-1:0]   i_mode,
    input  logic [pit_pkg::CMP_W-1:0]   i_cmp_even,
    input  logic [pit_pkg::CMP_W-1:0]   i_cmp_odd,
    input  pit_pkg::t_divs              i_div,
    output logic                        o_armed,
    output logic [PERIOD_WIDTH-1:0]     o_period
);
    import pit_pkg::*;

    localparam int PROD_W = TICKS_W + DIV_W;
    localparam int EXT_W  = (PERIOD_WIDTH > PROD_W) ? PERIOD_WIDTH : PROD_W;
    localparam logic [EXT_W-1:0] PMAX = EXT_W'({PERIOD_WIDTH{1'b1}});

    logic [1:0]         w_sel;
    logic               w_wide;
    logic [DIV_W-1:0]   w_div;
    logic [15:0]        w_c16;
    logic [TICKS_W-1:0] w_ticks;
    logic [PROD_W-1:0]  w_prod;
    logic [EXT_W-1:0]   w_prod_ext;

    assign w_sel  = i_odd ? i_mode[3:2] : i_mode[1:0];
    assign w_wide = (i_mode[7:6] == PAIR_16);

    // prescale source
    always_comb begin
        unique case (w_sel)
            SRC_EXT:  w_div = '0;
            SRC_T1:   w_div = i_div.t1;
            SRC_MID:  w_div = i_odd ? i_div.t16 : i_div.t4;
            SRC_HIGH: w_div = i_odd ? i_div.t256 : i_div.t16;
        endcase
    end

    // counts per period
    assign w_c16 = {i_cmp_odd, i_cmp_even};
    always_comb begin
        if (w_wide) begin
            w_ticks = (w_c16 == '0) ? FULL16 : TICKS_W'(w_c16);
        end else begin
            w_ticks = TICKS_W'(ticks8(i_odd ? i_cmp_odd : i_cmp_even));
        end
    end

    // period and saturation
    assign w_prod     = PROD_W'(w_ticks) * PROD_W'(w_div);
    assign w_prod_ext = EXT_W'(w_prod);
    assign o_period   = PERIOD_WIDTH'((w_prod_ext > PMAX) ? PMAX : w_prod_ext);
    assign o_armed    = i_run && (w_div != '0) && !(w_wide && i_odd);

endmodule

>>> rtl/paired_interval_timer.sv
// Four 8-bit interval timers in two pairs, driven one transaction per cycle:
// master tick, register write, register read or external pulse on timer 0.
// A new transaction is taken every cycle while the result register is not held
// by a stalled receiver; each one passes through the input register into the
// result register, and while a result waits only an empty input register can
// take the next transaction in. The longest path runs from the countdown compare
// through the compare latch into the per-timer period multiplier (17 x 13).
// Divisors sit behind the APB-style port and take effect at the next
// reschedule. No clearing pass after reset. Depends on pit_pkg, pit_cfg and
// pit_sched.
module paired_interval_timer #(
    parameter int PERIOD_WIDTH = pit_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_func,
    input  logic [7:0]                  i_addr,
    input  logic [7:0]                  i_wdata,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_rdata,
    output logic [3:0]                  o_irq_mask,
    output logic                        o_ff_pair0,
    output logic                        o_ff_pair1,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pit_pkg::CFG_AW-1:0]  paddr,
    input  logic [pit_pkg::CFG_DW-1:0]  pwdata,
    output logic [pit_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import pit_pkg::*;

    t_divs w_div;

    // input stage
    logic       r_in_valid;
    t_func      r_func;
    logic [7:0] r_addr;
    logic [7:0] r_wdata;
    logic       w_advance;

    // timer state
    logic [7:0]              r_run, n_run;
    logic [7:0]              r_mode [2];
    logic [7:0]              n_mode [2];
    logic [7:0]              r_ffc, n_ffc;
    logic [7:0]              r_dbc, n_dbc;
    logic [7:0]              r_cv [4];
    logic [7:0]              n_cv [4];
    logic [7:0]              r_cb [2];
    logic [7:0]              n_cb [2];
    logic [CNT_W-1:0]        r_up0, n_up0;
    logic [CNT_W-1:0]        r_up_odd [2];
    logic [CNT_W-1:0]        n_up_odd [2];
    logic [1:0]              r_lvl, n_lvl;
    logic [3:0]              r_armed, n_armed;
    logic [PERIOD_WIDTH-1:0] r_cd [4];
    logic [PERIOD_WIDTH-1:0] n_cd [4];

    // result stage
    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic [3:0] r_out_irq;
    logic [1:0] r_out_lvl;

    // per-item control
    logic [3:0]              w_tick_hit;
    logic [3:0]              w_resched;
    logic [1:0]              w_even_match;
    logic [1:0]              w_odd_tick;
    logic                    w_ext_count;
    logic                    w_ext_hit;
    logic [CNT_W-1:0]        w_up0_inc;
    logic                    w_recompute;
    logic [3:0]              w_irq;
    logic [7:0]              w_rdata;
    logic [1:0]              w_ff_en;
    logic [3:0]              w_sch_armed;
    logic [PERIOD_WIDTH-1:0] w_sch_period [4];

    function automatic logic ff_apply(input logic lvl, input logic [1:0] code);
        logic res;
        unique case (code)
            FF_TOGGLE: res = ~lvl;
            FF_SET:    res = 1'b1;
            FF_CLEAR:  res = 1'b0;
            FF_HOLD:   res = lvl;
        endcase
        return res;
    endfunction

    pit_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_div   (w_div)
    );

    // handshake
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign o_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func  <= t_func'(i_func);
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
        end
    end

    // countdown compare and external pulse count
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            w_tick_hit[n] = (r_func == FUNC_TICK) && r_armed[n]
                            && (r_cd[n] <= PERIOD_WIDTH'(1));
        end
    end

    assign w_up0_inc       = r_up0 + CNT_W'(1);
    assign w_ext_count     = (r_func == FUNC_EXT) && r_run[0] && (r_mode[0][1:0] == SRC_EXT);
    assign w_ext_hit       = w_ext_count && (w_up0_inc >= ticks8(r_cv[0]));
    assign w_even_match[0] = w_tick_hit[0] || w_ext_hit;
    assign w_even_match[1] = w_tick_hit[2];
    assign w_odd_tick      = {w_tick_hit[3], w_tick_hit[1]};
    assign w_ff_en         = {r_ffc[5], r_ffc[1]};

    // register access, matches, cascade and flip-flops
    always_comb begin
        logic             wide;
        logic             cas_en;
        logic             cas_hit;
        logic [CNT_W-1:0] cas_inc;

        n_run       = r_run;
        n_mode      = r_mode;
        n_ffc       = r_ffc;
        n_dbc       = r_dbc;
        n_cv        = r_cv;
        n_cb        = r_cb;
        n_up0       = r_up0;
        n_up_odd    = r_up_odd;
        n_lvl       = r_lvl;
        w_irq       = '0;
        w_rdata     = '0;
        w_recompute = 1'b0;

        if (r_func == FUNC_WRITE) begin
            unique case (r_addr)
                ADDR_RUN: begin
                    n_run       = r_wdata;
                    w_recompute = 1'b1;
                end
                ADDR_CMP0: begin
                    n_cb[0] = r_wdata;
                    if (!r_dbc[0]) begin
                        n_cv[0] = r_wdata;
                    end
                    w_recompute = 1'b1;
                end
                ADDR_CMP1: begin
                    n_cv[1]     = r_wdata;
                    w_recompute = 1'b1;
                end
                ADDR_MODE0: begin
                    n_mode[0]   = r_wdata;
                    w_recompute = 1'b1;
                end
                ADDR_FFC: begin
                    n_ffc    = r_wdata;
                    n_lvl[0] = ff_apply(r_lvl[0], r_wdata[3:2]);
                    n_lvl[1] = ff_apply(r_lvl[1], r_wdata[7:6]);
                end
                ADDR_CMP2: begin
                    n_cb[1] = r_wdata;
                    if (!r_dbc[1]) begin
                        n_cv[2] = r_wdata;
                    end
                    w_recompute = 1'b1;
                end
                ADDR_CMP3: begin
                    n_cv[3]     = r_wdata;
                    w_recompute = 1'b1;
                end
                ADDR_MODE1: begin
                    n_mode[1]   = r_wdata;
                    w_recompute = 1'b1;
                end
                ADDR_DBC: begin
                    n_dbc = r_wdata;
                end
                default: ;
            endcase
        end

        if (r_func == FUNC_READ) begin
            unique case (r_addr)
                ADDR_RUN:   w_rdata = r_run;
                ADDR_MODE0: w_rdata = r_mode[0];
                ADDR_FFC:   w_rdata = r_ffc | FFC_READ_SET;
                ADDR_MODE1: w_rdata = r_mode[1];
                ADDR_DBC:   w_rdata = r_dbc;
                default:    w_rdata = '0;
            endcase
        end

        // external pulse counts before any match clears it
        if (w_ext_count) begin
            n_up0 = w_up0_inc;
        end
        if (w_even_match[0] && (r_mode[0][7:6] != PAIR_16)) begin
            n_up0 = '0;
        end

        for (int p = 0; p < 2; p++) begin
            wide    = (r_mode[p][7:6] == PAIR_16);
            cas_en  = (r_mode[p][7:6] == PAIR_CASCADE) && (r_mode[p][3:2] == SRC_EXT)
                      && r_run[2*p+1];
            cas_inc = r_up_odd[p] + CNT_W'(1);
            cas_hit = w_even_match[p] && !wide && cas_en
                      && (cas_inc >= ticks8(r_cv[2*p+1]));
            if (w_even_match[p]) begin
                if (wide) begin
                    w_irq[2*p+1] = 1'b1;
                end else begin
                    w_irq[2*p] = 1'b1;
                end
                if (r_dbc[p]) begin
                    n_cv[2*p] = r_cb[p];
                end
                if (!wide && cas_en) begin
                    n_up_odd[p] = cas_inc;
                end
            end
            if (cas_hit || w_odd_tick[p]) begin
                w_irq[2*p+1] = 1'b1;
                n_up_odd[p]  = '0;
            end
            // each match toggles once, so the parity decides
            if ((w_even_match[p] ^ cas_hit ^ w_odd_tick[p]) && w_ff_en[p]) begin
                n_lvl[p] = ~r_lvl[p];
            end
        end
    end

    // period units, fed with the state this transaction leaves behind
    for (genvar n = 0; n < 4; n++) begin : g_sched
        pit_sched #(
            .PERIOD_WIDTH (PERIOD_WIDTH)
        ) u_sched (
            .i_odd      (1'(n % 2)),
            .i_run      (n_run[n]),
            .i_mode     (n_mode[n/2]),
            .i_cmp_even (n_cv[(n/2)*2]),
            .i_cmp_odd  (n_cv[(n/2)*2+1]),
            .i_div      (w_div),
            .o_armed    (w_sch_armed[n]),
            .o_period   (w_sch_period[n])
        );
    end

    // countdown update
    assign w_resched = {4{w_recompute}} | w_tick_hit;

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            n_armed[n] = r_armed[n];
            n_cd[n]    = r_cd[n];
            if (w_resched[n]) begin
                n_armed[n] = w_sch_armed[n];
                n_cd[n]    = w_sch_armed[n] ? w_sch_period[n] : '0;
            end else if ((r_func == FUNC_TICK) && r_armed[n]) begin
                n_cd[n] = r_cd[n] - PERIOD_WIDTH'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= '0;
            r_ffc    <= '0;
            r_dbc    <= '0;
            r_up0    <= '0;
            r_lvl    <= '0;
            r_armed  <= '0;
            for (int p = 0; p < 2; p++) begin
                r_mode[p]   <= '0;
                r_cb[p]     <= '0;
                r_up_odd[p] <= '0;
            end
            for (int n = 0; n < 4; n++) begin
                r_cv[n] <= '0;
                r_cd[n] <= '0;
            end
        end else if (w_advance) begin
            r_run    <= n_run;
            r_mode   <= n_mode;
            r_ffc    <= n_ffc;
            r_dbc    <= n_dbc;
            r_cv     <= n_cv;
            r_cb     <= n_cb;
            r_up0    <= n_up0;
            r_up_odd <= n_up_odd;
            r_lvl    <= n_lvl;
            r_armed  <= n_armed;
            r_cd     <= n_cd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_rdata <= w_rdata;
            r_out_irq   <= w_irq;
            r_out_lvl   <= n_lvl;
        end
    end

    assign o_rdata    = r_out_rdata;
    assign o_irq_mask = r_out_irq;
    assign o_ff_pair0 = r_out_lvl[0];
    assign o_ff_pair1 = r_out_lvl[1];

    // an odd timer never runs its own countdown in 16-bit pair mode
    a_odd_idle_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_armed[1] || (r_mode[0][7:6] != PAIR_16))
        && (!r_armed[3] || (r_mode[1][7:6] != PAIR_16)))
        else $error("odd timer armed in 16-bit pair mode");

    // an armed countdown always has ticks left
    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_armed[0] || (r_cd[0] != '0)) && (!r_armed[1] || (r_cd[1] != '0))
        && (!r_armed[2] || (r_cd[2] != '0)) && (!r_armed[3] || (r_cd[3] != '0)))
        else $error("armed timer with empty countdown");

    // cascade counts clear on reaching the compare, so they stay below 256
    a_cascade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_up_odd[0][CNT_W-1] && !r_up_odd[1][CNT_W-1])
        else $error("cascade count out of range");

    // a processed transaction always leaves a result behind
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed transaction lost its result");

endmodule

>>> tb/sv/paired_interval_timer_test.sv
// Self-checking testbench for paired_interval_timer: directed table, then random timer scenarios.
// Uses its own transaction-level model of the timers and checks each result against it or the directed table.
// Depends on pit_pkg and the paired_interval_timer RTL.
module paired_interval_timer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int        PW         = PERIOD_WIDTH_DEF;
    localparam logic [63:0] PERIOD_MAX = (64'd1 << PW) - 64'd1;
    localparam int        DIR_N      = 25;
    localparam int        PHASE_ITEMS = 130;

    // idling per phase: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 46, 0, 35};
    localparam int RECV_STALL [4] = '{0, 0, 46, 35};

    // prescale divisors per phase, t1 t4 t16 t256
    localparam logic [DIV_W-1:0] PHASE_DIV [4][4] = '{
        '{13'd1,    13'd2,    13'd3, 13'd4},
        '{13'd2,    13'd1,    13'd0, 13'd1},
        '{13'd4096, 13'd1,    13'd2, 13'd4096},
        '{13'd3,    13'd4096, 13'd1, 13'd0}
    };
    localparam logic [DIV_W-1:0] DIRECTED_DIV [4] = '{13'd1, 13'd4096, 13'd2, 13'd0};

    typedef struct packed {
        logic [7:0] rdata;
        logic [3:0] irq_mask;
        logic       ff0;
        logic       ff1;
    } timer_result_t;

    typedef struct packed {
        t_func         func;
        logic [7:0]    addr;
        logic [7:0]    wdata;
        logic          typed;
        timer_result_t res;
    } stim_row_t;

    // clock, reset and block inputs
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [1:0] i_func = FUNC_TICK;
    logic [7:0] i_addr = 8'h00;
    logic [7:0] i_wdata = 8'h00;
    logic i_ready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;

    logic o_ready;
    logic o_valid;
    logic [7:0] o_rdata;
    logic [3:0] o_irq_mask;
    logic o_ff_pair0;
    logic o_ff_pair1;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    paired_interval_timer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_addr     (i_addr),
        .i_wdata    (i_wdata),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rdata    (o_rdata),
        .o_irq_mask (o_irq_mask),
        .o_ff_pair0 (o_ff_pair0),
        .o_ff_pair1 (o_ff_pair1),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // run bookkeeping
    timer_result_t outputs_due [$];
    int err_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int irq_results = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // timer model state
    logic [DIV_W-1:0] div_cfg [4];
    logic [7:0]  run_m, ffc_m, dbc_m;
    logic [7:0]  mode_m [2];
    logic [7:0]  cmp_m [4];
    logic [7:0]  cmpbuf_m [2];
    logic [8:0]  upcnt_m [4];
    logic [63:0] remain_m [4];
    logic        armed_m [4];
    logic [1:0]  ff_m;
    logic [3:0]  irq_m;

    // directed table: flip-flop codes, unmapped access, external pulse, cascade,
    // 16-bit pair, double buffer, zero divisor and simultaneous matches
    stim_row_t directed_ops [DIR_N] = '{
        '{FUNC_READ,  ADDR_RUN,   8'h00, 1'b1, '{8'h00, 4'h0, 1'b0, 1'b0}},
        '{FUNC_READ,  ADDR_FFC,   8'h00, 1'b1, '{FFC_READ_SET, 4'h0, 1'b0, 1'b0}},
        '{FUNC_READ,  8'hFF,      8'hFF, 1'b1, '{8'h00, 4'h0, 1'b0, 1'b0}},
        '{FUNC_WRITE, 8'h00,      8'hFF, 1'b1, '{8'h00, 4'h0, 1'b0, 1'b0}},
        '{FUNC_WRITE, ADDR_FFC,   8'h44, 1'b1, '{8'h00, 4'h0, 1'b1, 1'b1}},
        '{FUNC_WRITE, ADDR_FFC,   8'hFF, 1'b1, '{8'h00, 4'h0, 1'b1, 1'b1}},
        '{FUNC_WRITE, ADDR_FFC,   8'h22, 1'b1, '{8'h00, 4'h0, 1'b0, 1'b0}},
        '{FUNC_EXT,   8'h00,      8'h00, 1'b1, '{8'h00, 4'h0, 1'b0, 1'b0}},
        '{FUNC_WRITE, ADDR_MODE0, 8'h00, 1'b0, '0},
        '{FUNC_WRITE, ADDR_CMP0,  8'h02, 1'b0, '0},
        '{FUNC_WRITE, ADDR_CMP1,  8'h02, 1'b0, '0},
        '{FUNC_WRITE, ADDR_RUN,   8'h03, 1'b0, '0},
        '{FUNC_EXT,   8'h00,      8'h00, 1'b0, '0},
        '{FUNC_EXT,   8'h00,      8'h00, 1'b0, '0},
        '{FUNC_EXT,   8'h00,      8'h00, 1'b0, '0},
        '{FUNC_EXT,   8'h00,      8'h00, 1'b0, '0},
        '{FUNC_WRITE, ADDR_MODE0, 8'h0D, 1'b0, '0},
        '{FUNC_WRITE, ADDR_MODE1, 8'h47, 1'b0, '0},
        '{FUNC_WRITE, ADDR_CMP2,  8'h01, 1'b0, '0},
        '{FUNC_WRITE, ADDR_CMP3,  8'h00, 1'b0, '0},
        '{FUNC_WRITE, ADDR_DBC,   8'h03, 1'b0, '0},
        '{FUNC_WRITE, ADDR_RUN,   8'hFF, 1'b0, '0},
        '{FUNC_TICK,  8'h00,      8'h00, 1'b0, '0},
        '{FUNC_TICK,  8'h00,      8'h00, 1'b0, '0},
        '{FUNC_READ,  ADDR_DBC,   8'h00, 1'b0, '0}
    };

    function automatic void clear_timer_model();
        for (int n = 0; n < 4; n++) begin
            div_cfg[n] = DIV_RST[n];
            cmp_m[n] = '0;
            upcnt_m[n] = '0;
            remain_m[n] = '0;
            armed_m[n] = 1'b0;
        end
        run_m = '0;
        ffc_m = '0;
        dbc_m = '0;
        mode_m[0] = '0;
        mode_m[1] = '0;
        cmpbuf_m[0] = '0;
        cmpbuf_m[1] = '0;
        ff_m = '0;
        irq_m = '0;
    endfunction

    function automatic logic [1:0] src_sel_of(int n);
        logic [7:0] m;
        m = mode_m[n >> 1];
        return n[0] ? m[3:2] : m[1:0];
    endfunction

    function automatic logic [DIV_W-1:0] divisor_for(int n);
        case (src_sel_of(n))
            SRC_T1:   return div_cfg[0];
            SRC_MID:  return n[0] ? div_cfg[2] : div_cfg[1];
            SRC_HIGH: return n[0] ? div_cfg[3] : div_cfg[2];
            default:  return '0;
        endcase
    endfunction

    // counts for an 8-bit compare, zero is full range
    function automatic logic [8:0] span8(int n);
        return (cmp_m[n] == 8'h00) ? 9'd256 : {1'b0, cmp_m[n]};
    endfunction

    // disarm, then re-arm a running schedulable timer with a full period
    function automatic void reload(int n);
        logic [DIV_W-1:0] dv;
        logic [15:0] c16;
        logic [16:0] cnt;
        logic [63:0] per;
        int pair;
        pair = n >> 1;
        dv = divisor_for(n);
        armed_m[n] = 1'b0;
        remain_m[n] = '0;
        if (!run_m[n]) return;
        if (mode_m[pair][7:6] == PAIR_16) begin
            if (n[0] || dv == '0) return;
            c16 = {cmp_m[n + 1], cmp_m[n]};
            cnt = (c16 == 16'h0000) ? FULL16 : {1'b0, c16};
        end else begin
            if (dv == '0) return;
            cnt = {8'h00, span8(n)};
        end
        per = 64'(cnt) * 64'(dv);
        if (per > PERIOD_MAX) per = PERIOD_MAX;
        armed_m[n] = 1'b1;
        remain_m[n] = per;
    endfunction

    function automatic void reload_all();
        for (int n = 0; n < 4; n++) reload(n);
    endfunction

    function automatic void toggle_pair(int pair);
        logic en;
        en = pair[0] ? ffc_m[5] : ffc_m[1];
        if (en) ff_m[pair] = ~ff_m[pair];
    endfunction

    function automatic void latch_buffer(int n);
        if (n == 0 && dbc_m[0]) cmp_m[0] = cmpbuf_m[0];
        if (n == 2 && dbc_m[1]) cmp_m[2] = cmpbuf_m[1];
    endfunction

    // one match; returns 1 when the cascaded odd timer matches as well
    function automatic logic fire_one(int n);
        int pair, even, odd;
        logic [1:0] pm;
        pair = n >> 1;
        even = pair * 2;
        odd = even + 1;
        pm = mode_m[pair][7:6];
        if (pm == PAIR_16 && !n[0]) begin
            irq_m[odd] = 1'b1;
            toggle_pair(pair);
            latch_buffer(even);
            return 1'b0;
        end
        irq_m[n] = 1'b1;
        upcnt_m[n] = '0;
        toggle_pair(pair);
        latch_buffer(n);
        if (pm == PAIR_CASCADE && n == even && src_sel_of(odd) == SRC_EXT && run_m[odd]) begin
            upcnt_m[odd] = upcnt_m[odd] + 9'd1;
            return upcnt_m[odd] >= span8(odd);
        end
        return 1'b0;
    endfunction

    function automatic void fire(int n);
        if (fire_one(n)) void'(fire_one(n | 1));
    endfunction

    function automatic void apply_ff_code(int pair, logic [1:0] code);
        case (code)
            FF_TOGGLE: ff_m[pair] = ~ff_m[pair];
            FF_SET:    ff_m[pair] = 1'b1;
            FF_CLEAR:  ff_m[pair] = 1'b0;
            default:   ;
        endcase
    endfunction

    function automatic void write_reg(logic [7:0] a, logic [7:0] d);
        case (a)
            ADDR_RUN: begin
                run_m = d;
                reload_all();
            end
            ADDR_CMP0: begin
                cmpbuf_m[0] = d;
                if (!dbc_m[0]) cmp_m[0] = d;
                reload_all();
            end
            ADDR_CMP1: begin
                cmp_m[1] = d;
                reload_all();
            end
            ADDR_MODE0: begin
                mode_m[0] = d;
                reload_all();
            end
            ADDR_FFC: begin
                ffc_m = d;
                apply_ff_code(0, d[3:2]);
                apply_ff_code(1, d[7:6]);
            end
            ADDR_CMP2: begin
                cmpbuf_m[1] = d;
                if (!dbc_m[1]) cmp_m[2] = d;
                reload_all();
            end
            ADDR_CMP3: begin
                cmp_m[3] = d;
                reload_all();
            end
            ADDR_MODE1: begin
                mode_m[1] = d;
                reload_all();
            end
            ADDR_DBC: dbc_m = d;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] read_reg(logic [7:0] a);
        case (a)
            ADDR_RUN:   return run_m;
            ADDR_MODE0: return mode_m[0];
            ADDR_FFC:   return ffc_m | FFC_READ_SET;
            ADDR_MODE1: return mode_m[1];
            ADDR_DBC:   return dbc_m;
            default:    return 8'h00;
        endcase
    endfunction

    // apply one transaction to the timer model and return its result
    function automatic timer_result_t step_timers(t_func f, logic [7:0] a, logic [7:0] d);
        timer_result_t r;
        r = '0;
        irq_m = '0;
        case (f)
            FUNC_TICK: begin
                for (int n = 0; n < 4; n++) begin
                    if (!armed_m[n]) continue;
                    if (remain_m[n] != 64'd0) remain_m[n] = remain_m[n] - 64'd1;
                    if (remain_m[n] == 64'd0) begin
                        fire(n);
                        reload(n);
                    end
                end
            end
            FUNC_WRITE: write_reg(a, d);
            FUNC_READ:  r.rdata = read_reg(a);
            FUNC_EXT: begin
                if (run_m[0] && mode_m[0][1:0] == SRC_EXT) begin
                    upcnt_m[0] = upcnt_m[0] + 9'd1;
                    if (upcnt_m[0] >= span8(0)) fire(0);
                end
            end
            default: ;
        endcase
        r.irq_mask = irq_m;
        r.ff0 = ff_m[0];
        r.ff1 = ff_m[1];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    // compare values lean small so timers match within a burst
    function automatic logic [7:0] pick_cmp();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 8'h00;
        if (r < 75) return 8'($urandom_range(4, 1));
        return rand8();
    endfunction

    function automatic logic [7:0] pick_mode();
        logic [7:0] m;
        int r;
        m = rand8();
        r = $urandom_range(99);
        if (r < 45) m[7:6] = PAIR_CASCADE;
        else if (r < 80) m[7:6] = PAIR_16;
        return m;
    endfunction

    // decoded window plus the unmapped hole at 0x21
    function automatic logic [7:0] reg_addr();
        return ADDR_RUN + 8'($urandom_range(9));
    endfunction

    // present one transaction, wait for acceptance, record its expected result
    task automatic send_op(input t_func f, input logic [7:0] a, input logic [7:0] d,
                           input logic typed = 1'b0, input timer_result_t want = '0);
        timer_result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_addr <= a;
        i_wdata <= d;
        do @(posedge i_clk); while (!o_ready);
        pred = step_timers(f, a, d);
        outputs_due.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge i_clk);
    endtask

    // apb register write: setup then access
    task automatic cfg_write(input int idx, input logic [DIV_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx * 4);
        pwdata <= CFG_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        div_cfg[idx] = v;
    endtask

    task automatic cfg_read_check(input int idx);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= CFG_AW'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != CFG_DW'(div_cfg[idx]))
            flag_mismatch($sformatf("divisor %0d reads %0d want %0d", idx, prdata, div_cfg[idx]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_divisors(input logic [DIV_W-1:0] dv [4]);
        for (int k = 0; k < 4; k++) cfg_write(k, dv[k]);
        for (int k = 0; k < 4; k++) cfg_read_check(k);
    endtask

    // one item inside a burst: mostly ticks, some pulses, reads, writes and noise
    task automatic burst_item();
        int r;
        logic [7:0] a;
        r = $urandom_range(99);
        a = reg_addr();
        if (r < 62) begin
            send_op(FUNC_TICK, rand8(), rand8());
        end else if (r < 74) begin
            send_op(FUNC_EXT, rand8(), rand8());
        end else if (r < 82) begin
            send_op(FUNC_READ, a, rand8());
        end else if (r < 92) begin
            if (a == ADDR_CMP0 || a == ADDR_CMP1 || a == ADDR_CMP2 || a == ADDR_CMP3)
                send_op(FUNC_WRITE, a, pick_cmp());
            else
                send_op(FUNC_WRITE, a, rand8());
        end else begin
            send_op(t_func'($urandom_range(3)), rand8(), rand8());
        end
    endtask

    // set up both pairs, start them, then let them run
    task automatic timer_scenario();
        logic run_first;
        int burst;
        run_first = ($urandom_range(99) < 20);
        burst = $urandom_range(40, 15);
        if (run_first) send_op(FUNC_WRITE, ADDR_RUN, rand8());
        send_op(FUNC_WRITE, ADDR_MODE0, pick_mode());
        send_op(FUNC_WRITE, ADDR_MODE1, pick_mode());
        send_op(FUNC_WRITE, ADDR_DBC, rand8());
        send_op(FUNC_WRITE, ADDR_CMP0, pick_cmp());
        send_op(FUNC_WRITE, ADDR_CMP1, pick_cmp());
        send_op(FUNC_WRITE, ADDR_CMP2, pick_cmp());
        send_op(FUNC_WRITE, ADDR_CMP3, pick_cmp());
        send_op(FUNC_WRITE, ADDR_FFC, rand8());
        if (!run_first) send_op(FUNC_WRITE, ADDR_RUN, rand8());
        repeat (burst) burst_item();
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin : check_results
        timer_result_t got;
        timer_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_rdata, o_irq_mask, o_ff_pair0, o_ff_pair1};
            if (outputs_due.size() == 0) begin
                flag_mismatch("result with no transaction pending");
            end else begin
                want = outputs_due.pop_front();
                if (got.rdata != want.rdata)
                    flag_mismatch($sformatf("rdata %02h want %02h", got.rdata, want.rdata));
                if (got.irq_mask != want.irq_mask)
                    flag_mismatch($sformatf("irq_mask %h want %h", got.irq_mask, want.irq_mask));
                if (got.ff0 != want.ff0)
                    flag_mismatch($sformatf("ff_pair0 %b want %b", got.ff0, want.ff0));
                if (got.ff1 != want.ff1)
                    flag_mismatch($sformatf("ff_pair1 %b want %b", got.ff1, want.ff1));
            end
            results_checked++;
            if (got.irq_mask != 4'h0) irq_results++;
        end
    end

    // main sequence
    initial begin : main_seq
        int start;
        logic [DIV_W-1:0] dv [4];
        clear_timer_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // divisor reset values, then the directed table
        for (int k = 0; k < 4; k++) cfg_read_check(k);
        set_divisors(DIRECTED_DIV);
        for (int k = 0; k < DIR_N; k++)
            send_op(directed_ops[k].func, directed_ops[k].addr, directed_ops[k].wdata,
                    directed_ops[k].typed, directed_ops[k].res);

        // random phases, each with its own idling and divisors
        for (int p = 0; p < 4; p++) begin
            drain();
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int k = 0; k < 4; k++) dv[k] = PHASE_DIV[p][k];
            set_divisors(dv);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) timer_scenario();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (outputs_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outputs_due.size()));
        $display("covered %0d transactions: directed table and four idling phases",
                 items_sent);
        $display("checked %0d results, %0d of them with interrupts", results_checked,
                 irq_results);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", outputs_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> paired_interval_timer.f
rtl/pit_pkg.sv
rtl/pit_cfg.sv
rtl/pit_sched.sv
rtl/paired_interval_timer.sv
tb/sv/paired_interval_timer_test.sv
